// File: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES    = 8;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W     = $clog2(ENTRIES + 1);
    localparam int TREE_N     = 2 ** IDX_W;

    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [FILL_W-1:0]     t_fill;
    typedef logic [SLOT_W-1:0]     t_slot;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic load_key;
        logic commit;
    } t_lfu_cmd;

    typedef struct packed {
        logic res_valid;
    } t_lfu_status;

endpackage

`default_nettype wire

// File: rtl/lfu_key_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfu_key_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

`default_nettype wire

// File: rtl/lfu_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfu_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [2:0]         slot;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, output ready);
endinterface

`default_nettype wire

// File: rtl/lfu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_res_ready,
    input  lfu_pkg::t_lfu_status i_status,
    output lfu_pkg::t_lfu_cmd    o_cmd
);

    lfu_pkg::t_state r_state;
    lfu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.load_key = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_key = 1'b1;
                    n_state        = lfu_pkg::ST_LOOKUP;
                end
            end
            lfu_pkg::ST_LOOKUP: begin
                // The update waits until the result register can take a new word.
                if (!i_status.res_valid || i_res_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_only_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> r_state == lfu_pkg::ST_LOOKUP)
        else $error("commit issued outside lookup");

    a_accept_leads_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == lfu_pkg::ST_LOOKUP && !o_in_ready))
        else $error("accepted word did not start a lookup");

    a_lookup_held_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_LOOKUP && i_status.res_valid && !i_res_ready)
        |=> r_state == lfu_pkg::ST_LOOKUP)
        else $error("lookup left while result register was full");

endmodule

`default_nettype wire

// File: rtl/lfu_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  lfu_pkg::t_lfu_cmd     i_cmd,
    output lfu_pkg::t_lfu_status  o_status,
    input  wire  [31:0]           i_key,
    input  wire                   i_res_ready,
    output logic                  o_res_valid,
    output logic                  o_res_hit,
    output logic [2:0]            o_res_slot,
    output logic                  o_res_evicted,
    output logic [31:0]           o_res_evicted_key
);

    lfu_pkg::t_key  r_keys   [lfu_pkg::ENTRIES];
    lfu_pkg::t_cnt  r_counts [lfu_pkg::ENTRIES];
    lfu_pkg::t_fill r_fill;
    lfu_pkg::t_key  r_key;

    logic           r_res_valid;
    logic           r_res_hit;
    lfu_pkg::t_slot r_res_slot;
    logic           r_res_evicted;
    lfu_pkg::t_key  r_res_evicted_key;

    logic          w_hit;
    lfu_pkg::t_idx w_hit_idx;
    logic          w_full;
    lfu_pkg::t_idx w_min_idx;
    lfu_pkg::t_idx w_slot;
    lfu_pkg::t_cnt w_tree_cnt [lfu_pkg::IDX_W+1][lfu_pkg::TREE_N];
    lfu_pkg::t_idx w_tree_idx [lfu_pkg::IDX_W+1][lfu_pkg::TREE_N];

    assign w_full = (r_fill == lfu_pkg::t_fill'(lfu_pkg::ENTRIES));

    // Parallel match against every valid entry; keys are unique, lowest index wins anyway.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
            if ((lfu_pkg::t_fill'(i) < r_fill) && (r_keys[i] == r_key)) begin
                w_hit     = 1'b1;
                w_hit_idx = lfu_pkg::t_idx'(i);
            end
        end
    end

    // Minimum tree. Padding leaves carry the largest count and a higher index than any
    // real entry, and the right side only wins when strictly smaller, so ties go low.
    always_comb begin
        for (int i = 0; i < lfu_pkg::TREE_N; i++) begin
            w_tree_cnt[0][i] = (i < lfu_pkg::ENTRIES) ? r_counts[i] : '1;
            w_tree_idx[0][i] = lfu_pkg::t_idx'(i);
        end
        for (int l = 1; l <= lfu_pkg::IDX_W; l++) begin
            for (int i = 0; i < lfu_pkg::TREE_N; i++) begin
                w_tree_cnt[l][i] = w_tree_cnt[l-1][i];
                w_tree_idx[l][i] = w_tree_idx[l-1][i];
                if ((i < (lfu_pkg::TREE_N >> l)) &&
                    (w_tree_cnt[l-1][2*i+1] < w_tree_cnt[l-1][2*i])) begin
                    w_tree_cnt[l][i] = w_tree_cnt[l-1][2*i+1];
                    w_tree_idx[l][i] = w_tree_idx[l-1][2*i+1];
                end else if (i < (lfu_pkg::TREE_N >> l)) begin
                    w_tree_cnt[l][i] = w_tree_cnt[l-1][2*i];
                    w_tree_idx[l][i] = w_tree_idx[l-1][2*i];
                end
            end
        end
        w_min_idx = w_tree_idx[lfu_pkg::IDX_W][0];
    end

    always_comb begin
        if (w_hit) begin
            w_slot = w_hit_idx;
        end else if (!w_full) begin
            w_slot = r_fill[lfu_pkg::IDX_W-1:0];
        end else begin
            w_slot = w_min_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_key;
        end
        if (i_cmd.commit && !w_hit) begin
            r_keys[w_slot] <= r_key;
        end
        if (i_cmd.commit) begin
            r_res_hit         <= w_hit;
            r_res_slot        <= lfu_pkg::t_slot'(w_slot);
            r_res_evicted     <= !w_hit && w_full;
            r_res_evicted_key <= (!w_hit && w_full) ? r_keys[w_slot] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                r_counts[i] <= '0;
            end
            r_fill      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (w_hit) begin
                    if (r_counts[w_slot] != '1) begin
                        r_counts[w_slot] <= r_counts[w_slot] + 1'b1;
                    end
                end else begin
                    r_counts[w_slot] <= '0;
                    if (!w_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_status.res_valid = r_res_valid;
    assign o_res_valid        = r_res_valid;
    assign o_res_hit          = r_res_hit;
    assign o_res_slot         = r_res_slot;
    assign o_res_evicted      = r_res_evicted;
    assign o_res_evicted_key  = r_res_evicted_key;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lfu_pkg::t_fill'(lfu_pkg::ENTRIES))
        else $error("fill level beyond store size");

    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_res_valid)
        else $error("commit did not load the result register");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |-> !i_cmd.commit)
        else $error("result overwritten before it was taken");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !w_full) |=> !r_res_evicted)
        else $error("eviction reported while store had free slots");

    a_fill_grows_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !w_hit && !w_full) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("insert did not advance fill level");

endmodule

`default_nettype wire

// File: rtl/lfu_cache_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// A key word is registered when accepted; its lookup and update then load the result register,
// which waits while the result is stalled. A new key word is accepted only after the lookup and
// update of the previous one through the single compare, minimum-search and write-back path.
// Reset is synchronous and active low: it clears use counts, fill level and the handshakes;
// stored keys are not cleared, since only entries below the fill level are ever matched.

module lfu_cache_replacement (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lfu_key_if.sink    i_key_ch,
    lfu_res_if.source  o_res_ch
);

    lfu_pkg::t_lfu_cmd    w_cmd;
    lfu_pkg::t_lfu_status w_status;
    logic                 w_in_ready;
    logic [31:0]          w_evicted_key;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key_ch.valid),
        .o_in_ready  (w_in_ready),
        .i_res_ready (o_res_ch.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lfu_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_key             (i_key_ch.key),
        .i_res_ready       (o_res_ch.ready),
        .o_res_valid       (o_res_ch.valid),
        .o_res_hit         (o_res_ch.hit),
        .o_res_slot        (o_res_ch.slot),
        .o_res_evicted     (o_res_ch.evicted),
        .o_res_evicted_key (w_evicted_key)
    );

    assign i_key_ch.ready       = w_in_ready;
    assign o_res_ch.evicted_key = w_evicted_key;

endmodule

`default_nettype wire
